[rtl/core/pidc_pkg.sv]
// Shared types, widths and codes for the dual-mode PID controller.
package pidc_pkg;

	// Gains are fixed point with this many fraction bits; products are shifted right by it.
	localparam int GAIN_FRAC_BITS = 8;

	localparam int DATA_W    = 16;
	localparam int ERR_W     = DATA_W + 1;
	localparam int SUM_W     = 32;
	localparam int LIMIT_W   = 15;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 3;
	localparam int ACC_W     = 50;
	localparam int CAND_W    = ACC_W + 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_COMPUTE = 2'd0,
		REQ_PRESET  = 2'd1,
		REQ_CLEAR   = 2'd2
	} req_type_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd4;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

	typedef struct packed {
		logic               loop_mode;
		logic [DATA_W-1:0]  kp_gain;
		logic [DATA_W-1:0]  ki_gain;
		logic [DATA_W-1:0]  kd_gain;
		logic [LIMIT_W-1:0] drive_limit;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [DATA_W-1:0] target_value;
		logic [DATA_W-1:0] sensed_value;
		logic [DATA_W-1:0] preset_value;
	} req_t;

	typedef struct packed {
		logic [SUM_W-1:0]  error_sum;
		logic [ERR_W-1:0]  prev_error;
		logic [ERR_W-1:0]  prev_prev_error;
		logic [DATA_W-1:0] held_drive;
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] drive_value;
		logic              was_clamped;
	} rsp_t;

endpackage

[rtl/core/pidc_req_if.sv]
// Request channel: valid/ready handshake with one request as payload.
interface pidc_req_if;
	import pidc_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [DATA_W-1:0] target_value;
	logic [DATA_W-1:0] sensed_value;
	logic [DATA_W-1:0] preset_value;

	modport source (output valid, output req_type, output target_value,
		output sensed_value, output preset_value, input ready);
	modport sink (input valid, input req_type, input target_value,
		input sensed_value, input preset_value, output ready);
endinterface

[rtl/core/pidc_rsp_if.sv]
// Response channel: valid/ready handshake carrying the drive value and clamp flag.
interface pidc_rsp_if;
	import pidc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] drive_value;
	logic              was_clamped;

	modport source (output valid, output drive_value, output was_clamped, input ready);
	modport sink (input valid, input drive_value, input was_clamped, output ready);
endinterface

[rtl/core/pidc_cfg_if.sv]
// Configuration write channel: valid/ready handshake with register index and data.
interface pidc_cfg_if;
	import pidc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/pidc_cfg_regs.sv]
// Configuration register file for the PID controller.
module pidc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	pidc_cfg_if.sink      cfg,
	output pidc_pkg::cfg_t cfg_q
);
	import pidc_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_mode   <= MODE_POSITIONAL;
			cfg_q.kp_gain     <= '0;
			cfg_q.ki_gain     <= '0;
			cfg_q.kd_gain     <= '0;
			cfg_q.drive_limit <= LIMIT_RESET;
		end else if (cfg.valid) begin
			// Writes to indexes past the last register are dropped.
			case (cfg.index)
				CFG_LOOP_MODE:   cfg_q.loop_mode   <= cfg.data[0];
				CFG_KP_GAIN:     cfg_q.kp_gain     <= cfg.data;
				CFG_KI_GAIN:     cfg_q.ki_gain     <= cfg.data;
				CFG_KD_GAIN:     cfg_q.kd_gain     <= cfg.data;
				CFG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

[rtl/core/pidc_datapath.sv]
// Single-pass PID arithmetic: error history, three shared multipliers, shift and clamp.
module pidc_datapath (
	input  pidc_pkg::cfg_t   cfg,
	input  pidc_pkg::state_t state,
	input  pidc_pkg::req_t   req,
	output pidc_pkg::state_t state_nxt,
	output pidc_pkg::rsp_t   rsp
);
	import pidc_pkg::*;

	logic signed [DATA_W-1:0]  kp, ki, kd, held;
	logic signed [ERR_W-1:0]   err, prev, pprev, lim17, neg_lim17, held17;
	logic signed [SUM_W:0]     sum_ext;
	logic signed [SUM_W-1:0]   es, es_sat;
	logic signed [ERR_W:0]     d, hist;
	logic signed [ERR_W+1:0]   dd;
	logic signed [ERR_W:0]     kp_op;
	logic signed [SUM_W-1:0]   ki_op;
	logic signed [ERR_W+1:0]   kd_op;
	logic signed [ERR_W+DATA_W:0]   kp_prod;
	logic signed [SUM_W+DATA_W-1:0] ki_prod;
	logic signed [ERR_W+DATA_W+1:0] kd_prod;
	logic                      incr, hold, use_ki;
	logic signed [ACC_W-1:0]   acc, shifted;
	logic signed [CAND_W-1:0]  cand, lim_c;
	logic signed [DATA_W-1:0]  clamped;
	logic                      clip;

	always_comb begin
		kp    = $signed(cfg.kp_gain);
		ki    = $signed(cfg.ki_gain);
		kd    = $signed(cfg.kd_gain);
		held  = $signed(state.held_drive);
		prev  = $signed(state.prev_error);
		pprev = $signed(state.prev_prev_error);
		es    = $signed(state.error_sum);
		incr  = (cfg.loop_mode == MODE_INCREMENTAL);

		err = ERR_W'($signed(req.target_value)) - ERR_W'($signed(req.sensed_value));

		// Integral saturates at the signed 32-bit bounds.
		sum_ext = (SUM_W+1)'(es) + (SUM_W+1)'(err);
		if (sum_ext[SUM_W] == sum_ext[SUM_W-1])
			es_sat = sum_ext[SUM_W-1:0];
		else
			es_sat = {sum_ext[SUM_W], {(SUM_W-1){~sum_ext[SUM_W]}}};

		d    = (ERR_W+1)'(err) - (ERR_W+1)'(prev);
		hist = (ERR_W+1)'(prev) - (ERR_W+1)'(pprev);
		dd   = (ERR_W+2)'(d) - (ERR_W+2)'(hist);

		// The same three multipliers serve both modes with different operands.
		kp_op = incr ? d : (ERR_W+1)'(err);
		ki_op = incr ? SUM_W'(err) : es_sat;
		kd_op = incr ? dd : (ERR_W+2)'(d);

		kp_prod = (ERR_W+DATA_W+1)'(kp_op) * (ERR_W+DATA_W+1)'(kp);
		ki_prod = (SUM_W+DATA_W)'(ki_op) * (SUM_W+DATA_W)'(ki);
		kd_prod = (ERR_W+DATA_W+2)'(kd_op) * (ERR_W+DATA_W+2)'(kd);

		lim17     = $signed({2'b00, cfg.drive_limit});
		neg_lim17 = -lim17;
		held17    = ERR_W'(held);

		// Conditional integration in incremental mode: stop integrating while the drive is pinned
		// at a limit and the error pushes it further out.
		hold   = (held17 >= lim17 && err > 0) || (held17 <= neg_lim17 && err < 0);
		use_ki = !(incr && hold);

		acc = ACC_W'(kp_prod) + ACC_W'(kd_prod) + (use_ki ? ACC_W'(ki_prod) : ACC_W'(0));
		shifted = acc >>> GAIN_FRAC_BITS;

		case (req.req_type)
			REQ_COMPUTE: cand = incr ? CAND_W'(shifted) + CAND_W'(held) : CAND_W'(shifted);
			REQ_PRESET:  cand = CAND_W'($signed(req.preset_value));
			default:     cand = '0;
		endcase

		lim_c = CAND_W'(lim17);
		if (cand > lim_c) begin
			clamped = DATA_W'(lim17);
			clip    = 1'b1;
		end else if (cand < -lim_c) begin
			clamped = DATA_W'(neg_lim17);
			clip    = 1'b1;
		end else begin
			clamped = cand[DATA_W-1:0];
			clip    = 1'b0;
		end

		state_nxt       = state;
		rsp.drive_value = state.held_drive;
		rsp.was_clamped = 1'b0;
		case (req.req_type)
			REQ_COMPUTE: begin
				if (incr) begin
					state_nxt.prev_prev_error = state.prev_error;
				end else begin
					state_nxt.error_sum = es_sat;
				end
				state_nxt.prev_error = err;
				state_nxt.held_drive = clamped;
				rsp.drive_value      = clamped;
				rsp.was_clamped      = clip;
			end
			REQ_PRESET: begin
				state_nxt.error_sum       = '0;
				state_nxt.prev_error      = '0;
				state_nxt.prev_prev_error = '0;
				state_nxt.held_drive      = clamped;
				rsp.drive_value           = clamped;
				rsp.was_clamped           = clip;
			end
			REQ_CLEAR: begin
				state_nxt       = '0;
				rsp.drive_value = '0;
			end
			default: ;
		endcase
	end
endmodule

[rtl/core/pid_controller_dual_mode.sv]
// Dual-mode PID controller top level: input register, PID pass, state and result registers.
// Throughput: one request per cycle while the result side takes results; the state update
// (integral, error history, held drive) completes in the single pass from the input register
// to the result register.
// Reset (arst_n low, asynchronous): all controller state is zero, gains zero, positional
// mode, drive limit 32767, both pipeline registers empty.
module pid_controller_dual_mode (
	input  logic       clk,
	input  logic       arst_n,
	pidc_req_if.sink   req,
	pidc_rsp_if.source rsp,
	pidc_cfg_if.sink   cfg
);
	import pidc_pkg::*;

	cfg_t   cfg_q;
	req_t   req_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_nxt;
	rsp_t   rsp_nxt;
	rsp_t   rsp_q;
	logic   rsp_valid_q;
	logic   advance;

	// Config registers; users write only while the controller is idle; unenforced.
	pidc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	// The input register moves into the result register whenever the result
	// register is empty or its transaction completes in this cycle. The input
	// side takes a new transaction whenever the input register is empty or
	// moving on, so one request can wait in the input register behind a held
	// result before the input side stalls.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// The request payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type     <= req.req_type;
			req_s1.target_value <= req.target_value;
			req_s1.sensed_value <= req.sensed_value;
			req_s1.preset_value <= req.preset_value;
		end
	end

	// All of the arithmetic for one request sits between the input register and
	// the result register. The controller state is read and rewritten in the
	// same pass, so back-to-back requests see each other's updates.
	pidc_datapath u_dp (
		.cfg       (cfg_q),
		.state     (state_q),
		.req       (req_s1),
		.state_nxt (state_nxt),
		.rsp       (rsp_nxt)
	);

	// Controller state commits only when the request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.drive_value = rsp_q.drive_value;
	assign rsp.was_clamped = rsp_q.was_clamped;
endmodule

[test/tb_pid_controller_dual_mode.sv]
// Self-checking testbench for the dual-mode PID controller with its own predictor.
module tb_pid_controller_dual_mode;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	// The request code that the block must treat as a no-op.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// Bounds of the saturating 32-bit integral.
	localparam longint INTEG_HI = 64'sd2147483647;
	localparam longint INTEG_LO = -64'sd2147483648;

	// Full-scale error samples per direction; the integral grows large but stays in range.
	localparam int SAT_SAMPLES = 40;

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 135;

	logic clk;
	logic arst_n;

	pidc_req_if req_ch ();
	pidc_rsp_if rsp_ch ();
	pidc_cfg_if cfg_ch ();

	pid_controller_dual_mode dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Configuration as the predictor believes the block holds it.
	logic                     mode_sel;
	logic signed [DATA_W-1:0] gain_p;
	logic signed [DATA_W-1:0] gain_i;
	logic signed [DATA_W-1:0] gain_d;
	logic [LIMIT_W-1:0]       clamp_lim;

	// Controller state of the predictor.
	logic signed [SUM_W-1:0]  integ_sum;
	logic signed [ERR_W-1:0]  err_last;
	logic signed [ERR_W-1:0]  err_before;
	logic signed [DATA_W-1:0] drive_now;

	// Drive values still owed by the block, oldest first.
	rsp_t expected_drive[$];
	int   pending;

	// When set, neither the request sender nor the result receiver inserts idle cycles.
	bit no_gaps;

	int n_requests;
	int n_results;
	int n_writes;
	int n_fail;

	always #5ns clk = ~clk;

	// Clips a value to the symmetric drive limit and flags whether clipping happened.
	function automatic rsp_t limit_drive(longint v);
		rsp_t   r;
		longint lim;
		lim = clamp_lim;
		r.was_clamped = 1'b1;
		if (v > lim) begin
			r.drive_value = 16'(lim);
		end else if (v < -lim) begin
			r.drive_value = 16'(-lim);
		end else begin
			r.drive_value = 16'(v);
			r.was_clamped = 1'b0;
		end
		return r;
	endfunction

	// Advances the predicted controller state by one request and returns the drive that
	// the block must report for it.
	function automatic rsp_t next_drive(req_t r);
		longint e;
		longint d;
		longint dd;
		longint acc;
		longint s;
		longint lim;
		logic   hold;
		rsp_t   res;
		lim = clamp_lim;
		res = '0;
		e = longint'($signed(r.target_value)) - longint'($signed(r.sensed_value));
		case (r.req_type)
			REQ_COMPUTE: begin
				if (mode_sel == MODE_POSITIONAL) begin
					// The integral rails at the 32-bit limits instead of wrapping.
					s = integ_sum + e;
					if (s > INTEG_HI)
						s = INTEG_HI;
					if (s < INTEG_LO)
						s = INTEG_LO;
					integ_sum = 32'(s);
					acc = gain_p * e + gain_i * integ_sum + gain_d * (e - err_last);
					res = limit_drive(acc >>> GAIN_FRAC_BITS);
					err_last = 17'(e);
				end else begin
					d = e - err_last;
					dd = d - (err_last - err_before);
					// Anti-windup: no integral step while pinned at a rail and pushing outward.
					hold = (drive_now >= lim && e > 0) || (drive_now <= -lim && e < 0);
					acc = gain_p * d + gain_d * dd;
					if (!hold)
						acc = acc + gain_i * e;
					res = limit_drive(drive_now + (acc >>> GAIN_FRAC_BITS));
					err_before = err_last;
					err_last = 17'(e);
				end
				drive_now = res.drive_value;
			end
			REQ_PRESET: begin
				res = limit_drive($signed(r.preset_value));
				drive_now = res.drive_value;
				integ_sum = '0;
				err_last = '0;
				err_before = '0;
			end
			REQ_CLEAR: begin
				integ_sum = '0;
				err_last = '0;
				err_before = '0;
				drive_now = '0;
			end
			default: begin
				res.drive_value = drive_now;
			end
		endcase
		return res;
	endfunction

	// Sends one request after a random idle stretch, none when no_gaps is set, and records
	// what it must produce. The valid stays high afterwards so that back-to-back requests need no toggle.
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] tgt,
		input logic [DATA_W-1:0] sns, input logic [DATA_W-1:0] pre);
		req_t item;
		int   gap;
		item.req_type = kind;
		item.target_value = tgt;
		item.sensed_value = sns;
		item.preset_value = pre;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.target_value <= tgt;
		req_ch.sensed_value <= sns;
		req_ch.preset_value <= pre;
		do @(posedge clk); while (!req_ch.ready);
		expected_drive.push_back(next_drive(item));
		pending++;
		n_requests++;
	endtask

	// Stops sending and waits until every outstanding result has been checked.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (2) @(posedge clk);
	endtask

	// Writes all five registers while the block is idle.
	task automatic configure(input logic [DATA_W-1:0] mode_data, input logic [DATA_W-1:0] kp,
		input logic [DATA_W-1:0] ki, input logic [DATA_W-1:0] kd,
		input logic [DATA_W-1:0] lim_data);
		logic [CFG_IDX_W-1:0] regs[5];
		logic [DATA_W-1:0]    vals[5];
		drain_results();
		regs = '{CFG_LOOP_MODE, CFG_KP_GAIN, CFG_KI_GAIN, CFG_KD_GAIN, CFG_DRIVE_LIMIT};
		vals = '{mode_data, kp, ki, kd, lim_data};
		for (int i = 0; i < 5; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[i];
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			n_writes++;
		end
		cfg_ch.valid <= 1'b0;
		// Only the low bit of the mode and the low 15 bits of the limit are kept.
		mode_sel = mode_data[0];
		gain_p = kp;
		gain_i = ki;
		gain_d = kd;
		clamp_lim = lim_data[LIMIT_W-1:0];
	endtask

	// Gains are either at an extreme, anywhere in range, or small.
	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			1: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 1024)) - 512);
		endcase
	endfunction

	// Samples are mostly near zero, with a share spread over the whole range.
	function automatic logic [DATA_W-1:0] pick_sample();
		if ($urandom_range(0, 9) < 3)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 400)) - 200);
	endfunction

	// Right after reset the gains are zero and the limit is full scale, so every computed
	// drive is zero while presets are clipped only at the most negative code.
	task automatic test_reset_defaults();
		send_request(REQ_COMPUTE, 16'sh7FFF, 16'sh8000, 16'h0);
		send_request(REQ_COMPUTE, 16'sh8000, 16'sh7FFF, 16'h0);
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'sh7FFF);
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'sh8000);
		send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	// Full-scale errors against extreme gains, then the floor rounding of the shift.
	task automatic test_positional_extremes();
		configure({15'h7FFF, MODE_POSITIONAL}, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		send_request(REQ_COMPUTE, 16'sh7FFF, 16'sh8000, 16'h0);
		send_request(REQ_COMPUTE, 16'sh8000, 16'sh7FFF, 16'h0);
		send_request(REQ_COMPUTE, 16'sh8000, 16'sh8000, 16'h0);
		configure({15'h0, MODE_POSITIONAL}, 16'sd1, 16'sd0, 16'sd0, 16'sd32767);
		send_request(REQ_COMPUTE, 16'sd0, 16'sd1, 16'h0);
		send_request(REQ_COMPUTE, 16'sd255, 16'sd0, 16'h0);
		send_request(REQ_COMPUTE, 16'sd0, 16'sd256, 16'h0);
	endtask

	// In incremental mode the integral step is held while the drive rests on a rail and the
	// error points further out, and released as soon as the error turns back.
	task automatic test_incremental_hold();
		configure({15'h7FFF, MODE_INCREMENTAL}, 16'sd0, 16'sd256, 16'sd0, 16'sd100);
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'sd100);
		send_request(REQ_COMPUTE, 16'sd5, 16'sd0, 16'h0);
		send_request(REQ_COMPUTE, -16'sd5, 16'sd0, 16'h0);
		send_request(REQ_PRESET, 16'h0, 16'h0, -16'sd100);
		send_request(REQ_COMPUTE, -16'sd5, 16'sd0, 16'h0);
		send_request(REQ_COMPUTE, 16'sd5, 16'sd0, 16'h0);
		configure({15'h0, MODE_INCREMENTAL}, 16'sd300, -16'sd40, 16'sd500, 16'sd2000);
		send_request(REQ_COMPUTE, 16'sd10, 16'sd0, 16'h0);
		send_request(REQ_COMPUTE, 16'sd30, -16'sd7, 16'h0);
		send_request(REQ_COMPUTE, -16'sd20, 16'sd0, 16'h0);
		send_request(REQ_COMPUTE, 16'sh7FFF, 16'sh8000, 16'h0);
	endtask

	// A zero limit pins every computed and preset drive at zero.
	task automatic test_zero_limit();
		configure({15'h0, MODE_POSITIONAL}, 16'sd256, 16'sd256, 16'sd256, 16'h8000);
		send_request(REQ_COMPUTE, 16'sd10, 16'sd0, 16'h0);
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'sd5);
		configure({15'h0, MODE_INCREMENTAL}, 16'sd256, 16'sd256, 16'sd256, 16'h0);
		send_request(REQ_COMPUTE, -16'sd3, 16'sd0, 16'h0);
	endtask

	// Presets and clears wipe the error history and integral; the unused code leaves all
	// state alone and reports the held drive.
	task automatic test_preset_and_clear();
		configure({15'h0, MODE_POSITIONAL}, 16'sd0, 16'sd256, 16'sd0, 16'sd32767);
		send_request(REQ_COMPUTE, 16'sd100, 16'sd0, 16'h0);
		send_request(REQ_COMPUTE, 16'sd100, 16'sd0, 16'h0);
		send_request(REQ_UNUSED, 16'sd1, 16'sd2, 16'sd3);
		send_request(REQ_CLEAR, 16'sd1, 16'sd2, 16'sd3);
		send_request(REQ_COMPUTE, 16'sd100, 16'sd0, 16'h0);
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'sd7);
		send_request(REQ_COMPUTE, 16'sd1, 16'sd0, 16'h0);
	endtask

	// A run of full-scale error builds a large integral in each direction. With only the
	// smallest integral gain, the drive follows the integral shifted down by the fraction.
	task automatic test_integral_buildup();
		configure({15'h0, MODE_POSITIONAL}, 16'sd0, 16'sd1, 16'sd0, 16'sd32767);
		no_gaps = 1'b1;
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'h0);
		repeat (SAT_SAMPLES) send_request(REQ_COMPUTE, 16'sh7FFF, 16'sh8000, 16'h0);
		send_request(REQ_PRESET, 16'h0, 16'h0, 16'h0);
		repeat (SAT_SAMPLES) send_request(REQ_COMPUTE, 16'sh8000, 16'sh7FFF, 16'h0);
		drain_results();
		no_gaps = 1'b0;
	endtask

	// Random request mix over several register settings, the limit extremes among them.
	task automatic test_random_traffic();
		logic [LIMIT_W-1:0] lim;
		int                 pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				2: lim = '0;
				5: lim = LIMIT_RESET;
				default: lim = $urandom_range(0, 1) ? 15'($urandom_range(1, 500)) : 15'($urandom);
			endcase
			configure({15'($urandom), 1'(phase % 2)}, pick_gain(), pick_gain(), pick_gain(),
				{1'($urandom), lim});
			no_gaps = (phase == 1) || ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 82)
					send_request(REQ_COMPUTE, pick_sample(), pick_sample(), pick_sample());
				else if (pick < 90)
					send_request(REQ_PRESET, pick_sample(), pick_sample(), pick_sample());
				else if (pick < 95)
					send_request(REQ_CLEAR, pick_sample(), pick_sample(), pick_sample());
				else
					send_request(REQ_UNUSED, pick_sample(), pick_sample(), pick_sample());
			end
			drain_results();
			no_gaps = 1'b0;
		end
	endtask

	// The result side stalls randomly before taking each transaction, unless no_gaps is set.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Every result transaction is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (expected_drive.size() == 0) begin
				$error("drive_value: no result expected, got %0d", $signed(rsp_ch.drive_value));
				n_fail++;
			end else begin
				want = expected_drive.pop_front();
				pending--;
				if (rsp_ch.drive_value !== want.drive_value) begin
					$error("drive_value: expected %0d, got %0d", $signed(want.drive_value),
						$signed(rsp_ch.drive_value));
					n_fail++;
				end
				if (rsp_ch.was_clamped !== want.was_clamped) begin
					$error("was_clamped: expected %0b, got %0b", want.was_clamped,
						rsp_ch.was_clamped);
					n_fail++;
				end
			end
		end
	end

	// Hard stop in case the block stops answering.
	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_COMPUTE;
		req_ch.target_value <= '0;
		req_ch.sensed_value <= '0;
		req_ch.preset_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_LOOP_MODE;
		cfg_ch.data <= '0;
		no_gaps = 1'b0;
		pending = 0;
		n_requests = 0;
		n_results = 0;
		n_writes = 0;
		n_fail = 0;
		// Predictor starts from the documented reset state.
		mode_sel = MODE_POSITIONAL;
		gain_p = '0;
		gain_i = '0;
		gain_d = '0;
		clamp_lim = LIMIT_RESET;
		integ_sum = '0;
		err_last = '0;
		err_before = '0;
		drive_now = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_positional_extremes();
		test_incremental_hold();
		test_zero_limit();
		test_preset_and_clear();
		test_integral_buildup();
		test_random_traffic();

		drain_results();
		repeat (5) @(posedge clk);
		$display("Run covered %0d requests, %0d results and %0d register writes; %0d mismatches.",
			n_requests, n_results, n_writes, n_fail);
		$display("Both loop modes, presets, clears, the unused code, zero and full limits, %s",
			"and a large integral in both directions were exercised.");
		if (n_fail == 0 && expected_drive.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
